// ----- design/xedt_pkg.sv -----
// Shared types, codes and character constants for the XML entity-decoding tokenizer.
`default_nettype none

package xedt_pkg;

    localparam int ENTITY_MAX_DEF = 8;
    localparam int MAX_RESULTS    = 20;
    localparam int RES_CW         = $clog2(MAX_RESULTS + 1);

    // token kinds
    localparam logic [3:0] TK_EOF    = 4'd0;
    localparam logic [3:0] TK_EQUALS = 4'd1;
    localparam logic [3:0] TK_CLOSE  = 4'd2;
    localparam logic [3:0] TK_BANG   = 4'd3;
    localparam logic [3:0] TK_SLASH  = 4'd4;
    localparam logic [3:0] TK_QUEST  = 4'd5;
    localparam logic [3:0] TK_OPEN   = 4'd6;
    localparam logic [3:0] TK_NAME   = 4'd7;
    localparam logic [3:0] TK_STRING = 4'd8;
    localparam logic [3:0] TK_ERROR  = 4'd9;

    // characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_P     = 8'h70;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_stream;
    } t_in;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] char_value;
        logic       char_valid;
        logic       was_escaped;
        logic       token_end;
        logic       last_of_item;
    } t_out;

    // one datapath step per cycle while running and the output is not blocked
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_LEX     = 3'd1,
        OP_RESOLVE = 3'd2,
        OP_RES_EOF = 3'd3,
        OP_DEC_IN  = 3'd4,
        OP_DEC_Q   = 3'd5,
        OP_EOF_LEX = 3'd6
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic cur_v;
        logic res_pend;
        logic in_v;
        logic q_nonempty;
        logic eof;
        logic eof_done;
        logic ent_active;
        logic pend_v;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ----- design/xedt_ctrl.sv -----
// Controller: sequences datapath steps for one word and flushes its last result.
`default_nettype none

module xedt_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire xedt_pkg::t_status i_status,
    output xedt_pkg::t_cmd        o_cmd,
    output logic                  o_in_stall
);
    import xedt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   blocked;

    assign blocked    = i_status.pend_v && !i_status.out_free;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.op    = OP_NONE;
        o_cmd.flush = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (!blocked) begin
                    // lexer first, then decoder, input before replay
                    if (i_status.cur_v) begin
                        o_cmd.op = OP_LEX;
                    end else if (i_status.res_pend) begin
                        o_cmd.op = OP_RESOLVE;
                    end else if (i_status.in_v) begin
                        o_cmd.op = OP_DEC_IN;
                    end else if (i_status.q_nonempty) begin
                        o_cmd.op = OP_DEC_Q;
                    end else if (i_status.eof && i_status.ent_active) begin
                        o_cmd.op = OP_RES_EOF;
                    end else if (i_status.eof && !i_status.eof_done) begin
                        o_cmd.op = OP_EOF_LEX;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_status.pend_v) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- design/xedt_dp.sv -----
// Datapath: entity buffer, replay queue, lexer step, result hold and output registers.
`default_nettype none

module xedt_dp #(
    parameter int ENTITY_MAX = xedt_pkg::ENTITY_MAX_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire xedt_pkg::t_in     i_in_word,
    input  wire xedt_pkg::t_cmd    i_cmd,
    input  wire logic              i_out_stall,
    output xedt_pkg::t_status      o_status,
    output xedt_pkg::t_out         o_out_word,
    output logic                   o_out_valid
);
    import xedt_pkg::*;

    localparam int CW = $clog2(ENTITY_MAX + 1);
    localparam int IW = $clog2(ENTITY_MAX);
    localparam logic [CW-1:0] EM_C = CW'(ENTITY_MAX);
    localparam logic [RES_CW-1:0] MAXRES_C = RES_CW'(MAX_RESULTS);

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_NAME   = 4'b0010,
        MODE_STRING = 4'b0100,
        MODE_LT     = 4'b1000
    } t_lex_mode;

    t_lex_mode r_mode, n_mode, lx_mode;

    logic [7:0]  r_ebuf [ENTITY_MAX];
    logic [7:0]  r_rq   [ENTITY_MAX];
    logic [CW-1:0] r_ecnt, n_ecnt, r_qhead, n_qhead, r_qlen, n_qlen;
    logic        r_eact, n_eact, r_res, n_res, r_from_q, n_from_q;
    logic        r_cur_v, n_cur_v, r_cur_esc, n_cur_esc, r_cur_eof, n_cur_eof;
    logic [7:0]  r_cur_c, n_cur_c;
    logic        r_in_v, n_in_v, r_eof, n_eof, r_eof_done, n_eof_done;
    logic [7:0]  r_in_b, n_in_b;
    logic        r_pend_v, n_pend_v, r_out_v, n_out_v;
    t_out        r_pend, n_pend, r_out, n_out;
    logic [RES_CW-1:0] r_nres, n_nres;

    logic        out_free, ebuf_we, q_load, in_eof;
    logic [7:0]  dec_b;
    logic [CW-1:0] ecnt_inc;

    logic        lx_emit, lx_done;
    t_out        lx_res;

    logic        m_lt, m_gt, m_quot, m_amp, match_v;
    logic [7:0]  match_c;

    function automatic logic is_name(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_COLON;
    endfunction

    // ---------------- lexer step ----------------
    always_comb begin
        lx_emit            = 1'b0;
        lx_done            = 1'b1;
        lx_mode            = MODE_IDLE;
        lx_res             = '0;
        lx_res.token_kind  = TK_EOF;
        lx_res.token_end   = 1'b1;
        unique case (r_mode)
            MODE_NAME: begin
                lx_emit           = 1'b1;
                lx_res.token_kind = TK_NAME;
                if (!r_cur_eof && !r_cur_esc && is_name(r_cur_c)) begin
                    lx_res.char_value = r_cur_c;
                    lx_res.char_valid = 1'b1;
                    lx_res.token_end  = 1'b0;
                    lx_mode           = MODE_NAME;
                end else begin
                    lx_done = 1'b0;   // terminating char is lexed again from idle
                end
            end
            MODE_STRING: begin
                lx_emit           = 1'b1;
                lx_res.token_kind = TK_STRING;
                if (r_cur_eof || (!r_cur_esc && r_cur_c == CH_QUOTE)) begin
                    lx_done = !r_cur_eof;
                end else begin
                    lx_res.char_value  = r_cur_c;
                    lx_res.char_valid  = 1'b1;
                    lx_res.was_escaped = r_cur_esc;
                    lx_res.token_end   = 1'b0;
                    lx_mode            = MODE_STRING;
                end
            end
            MODE_LT: begin
                lx_emit = 1'b1;
                if (!r_cur_eof && !r_cur_esc && r_cur_c == CH_BANG) begin
                    lx_res.token_kind = TK_BANG;
                end else if (!r_cur_eof && !r_cur_esc && r_cur_c == CH_SLASH) begin
                    lx_res.token_kind = TK_SLASH;
                end else if (!r_cur_eof && !r_cur_esc && r_cur_c == CH_QUEST) begin
                    lx_res.token_kind = TK_QUEST;
                end else begin
                    lx_res.token_kind = TK_OPEN;
                    lx_done           = 1'b0;
                end
            end
            default: begin
                if (r_cur_eof) begin
                    lx_emit           = 1'b1;
                    lx_res.token_kind = TK_EOF;
                end else if (r_cur_esc) begin
                    lx_emit           = 1'b1;
                    lx_res.token_kind = TK_ERROR;
                end else if (r_cur_c <= CH_SPACE) begin
                    lx_emit = 1'b0;
                end else if (r_cur_c == CH_EQ) begin
                    lx_emit           = 1'b1;
                    lx_res.token_kind = TK_EQUALS;
                end else if (r_cur_c == CH_GT) begin
                    lx_emit           = 1'b1;
                    lx_res.token_kind = TK_CLOSE;
                end else if (r_cur_c == CH_LT) begin
                    lx_mode = MODE_LT;
                end else if (r_cur_c == CH_QUOTE) begin
                    lx_mode = MODE_STRING;
                end else if (is_name(r_cur_c)) begin
                    lx_emit           = 1'b1;
                    lx_res.token_kind = TK_NAME;
                    lx_res.char_value = r_cur_c;
                    lx_res.char_valid = 1'b1;
                    lx_res.token_end  = 1'b0;
                    lx_mode           = MODE_NAME;
                end else begin
                    lx_emit           = 1'b1;
                    lx_res.token_kind = TK_ERROR;
                end
            end
        endcase
    end

    // ---------------- entity match ----------------
    assign m_lt   = (r_ecnt == CW'(3)) && r_ebuf[0] == CH_L && r_ebuf[1] == CH_T &&
                    r_ebuf[2] == CH_SEMI;
    assign m_gt   = (r_ecnt == CW'(3)) && r_ebuf[0] == CH_G && r_ebuf[1] == CH_T &&
                    r_ebuf[2] == CH_SEMI;
    assign m_quot = (r_ecnt == CW'(5)) && r_ebuf[0] == CH_Q && r_ebuf[1] == CH_U &&
                    r_ebuf[2] == CH_O && r_ebuf[3] == CH_T && r_ebuf[4] == CH_SEMI;
    assign m_amp  = (r_ecnt == CW'(4)) && r_ebuf[0] == CH_A && r_ebuf[1] == CH_M &&
                    r_ebuf[2] == CH_P && r_ebuf[3] == CH_SEMI;
    assign match_v = m_lt || m_gt || m_quot || m_amp;
    assign match_c = m_lt ? CH_LT : (m_gt ? CH_GT : (m_quot ? CH_QUOTE : CH_AMP));

    assign out_free = !r_out_v || !i_out_stall;
    assign dec_b    = (i_cmd.op == OP_DEC_IN) ? r_in_b : r_rq[r_qhead[IW-1:0]];
    assign ecnt_inc = r_ecnt + CW'(1);
    assign in_eof   = i_in_word.end_of_stream || (i_in_word.byte_value == 8'h00);

    // ---------------- step control ----------------
    always_comb begin
        n_mode     = r_mode;
        n_ecnt     = r_ecnt;
        n_qhead    = r_qhead;
        n_qlen     = r_qlen;
        n_eact     = r_eact;
        n_res      = r_res;
        n_from_q   = r_from_q;
        n_cur_v    = r_cur_v;
        n_cur_esc  = r_cur_esc;
        n_cur_eof  = r_cur_eof;
        n_cur_c    = r_cur_c;
        n_in_v     = r_in_v;
        n_in_b     = r_in_b;
        n_eof      = r_eof;
        n_eof_done = r_eof_done;
        n_nres     = r_nres;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        n_out_v    = r_out_v && !out_free;
        n_out      = r_out;
        ebuf_we    = 1'b0;
        q_load     = 1'b0;

        unique case (i_cmd.op)
            OP_LEX: begin
                n_mode = lx_mode;
                if (lx_done) begin
                    n_cur_v = 1'b0;
                end
                if (lx_emit && r_nres < MAXRES_C) begin
                    n_nres = r_nres + RES_CW'(1);
                    if (r_pend_v) begin
                        n_out   = r_pend;
                        n_out_v = 1'b1;
                    end
                    n_pend   = lx_res;
                    n_pend_v = 1'b1;
                end
            end
            OP_DEC_IN, OP_DEC_Q: begin
                if (i_cmd.op == OP_DEC_IN) begin
                    n_in_v = 1'b0;
                end else begin
                    n_qhead = r_qhead + CW'(1);
                end
                if (r_eact) begin
                    ebuf_we = 1'b1;
                    n_ecnt  = ecnt_inc;
                    if (dec_b == CH_SEMI || ecnt_inc >= EM_C) begin
                        n_res    = 1'b1;
                        n_from_q = (i_cmd.op == OP_DEC_Q);
                    end
                end else if (dec_b == CH_AMP) begin
                    n_eact = 1'b1;
                    n_ecnt = '0;
                end else begin
                    n_cur_v   = 1'b1;
                    n_cur_c   = dec_b;
                    n_cur_esc = 1'b0;
                    n_cur_eof = 1'b0;
                end
            end
            OP_RESOLVE, OP_RES_EOF: begin
                n_eact    = 1'b0;
                n_ecnt    = '0;
                n_res     = 1'b0;
                n_cur_v   = 1'b1;
                n_cur_eof = 1'b0;
                if (match_v) begin
                    n_cur_c   = match_c;
                    n_cur_esc = 1'b1;
                end else begin
                    n_cur_c   = CH_AMP;
                    n_cur_esc = 1'b0;
                    // bytes gathered from the queue are still there: just back up
                    if (i_cmd.op == OP_RESOLVE && r_from_q) begin
                        n_qhead = r_qhead - r_ecnt;
                    end else begin
                        q_load  = 1'b1;
                        n_qhead = '0;
                        n_qlen  = r_ecnt;
                    end
                end
            end
            OP_EOF_LEX: begin
                n_cur_v    = 1'b1;
                n_cur_c    = 8'h00;
                n_cur_esc  = 1'b0;
                n_cur_eof  = 1'b1;
                n_eof_done = 1'b1;
            end
            default: begin
            end
        endcase

        if (i_cmd.load) begin
            n_eof      = in_eof;
            n_in_v     = !in_eof;
            n_in_b     = i_in_word.byte_value;
            n_eof_done = 1'b0;
            n_nres     = '0;
        end

        if (i_cmd.flush) begin
            n_out              = r_pend;
            n_out.last_of_item = 1'b1;
            n_out_v            = 1'b1;
            n_pend_v           = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_ecnt     <= '0;
            r_qhead    <= '0;
            r_qlen     <= '0;
            r_eact     <= 1'b0;
            r_res      <= 1'b0;
            r_from_q   <= 1'b0;
            r_cur_v    <= 1'b0;
            r_in_v     <= 1'b0;
            r_eof      <= 1'b0;
            r_eof_done <= 1'b0;
            r_nres     <= '0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_ecnt     <= n_ecnt;
            r_qhead    <= n_qhead;
            r_qlen     <= n_qlen;
            r_eact     <= n_eact;
            r_res      <= n_res;
            r_from_q   <= n_from_q;
            r_cur_v    <= n_cur_v;
            r_in_v     <= n_in_v;
            r_eof      <= n_eof;
            r_eof_done <= n_eof_done;
            r_nres     <= n_nres;
            r_pend_v   <= n_pend_v;
            r_out_v    <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_c   <= n_cur_c;
        r_cur_esc <= n_cur_esc;
        r_cur_eof <= n_cur_eof;
        r_in_b    <= n_in_b;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (ebuf_we) begin
            r_ebuf[r_ecnt[IW-1:0]] <= dec_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_load) begin
            for (int k = 0; k < ENTITY_MAX; k++) begin
                r_rq[k] <= r_ebuf[k];
            end
        end
    end

    assign o_status.cur_v      = r_cur_v;
    assign o_status.res_pend   = r_res;
    assign o_status.in_v       = r_in_v;
    assign o_status.q_nonempty = (r_qhead < r_qlen);
    assign o_status.eof        = r_eof;
    assign o_status.eof_done   = r_eof_done;
    assign o_status.ent_active = r_eact;
    assign o_status.pend_v     = r_pend_v;
    assign o_status.out_free   = out_free;

    assign o_out_word  = r_out;
    assign o_out_valid = r_out_v;

    a_qhead_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qhead <= r_qlen)
        else $error("replay head past replay length");

    a_ecnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_eact |-> r_ecnt == '0)
        else $error("entity count nonzero with no entity open");

    a_res_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res |-> r_eact && r_ecnt != '0)
        else $error("resolve pending without gathered entity");

    a_ecnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= EM_C && r_qlen <= EM_C)
        else $error("entity count or replay length beyond buffer");

endmodule

`default_nettype wire

// ----- design/xml_entity_decoding_tokenizer.sv -----
// An accepted word is decoded and lexed one step at a time; its last result, if any, is
// flushed to the output register before the next word is taken, and the input stalls
// meanwhile. Lexer steps, decoded bytes and entity resolutions share the single step
// unit, so a failed entity replays each gathered byte through the decoder and lexer.
// Reset (i_rst_n low, synchronous): lexer idle, no entity open, replay queue and
// output empty; the entity and replay buffers are not cleared.
`default_nettype none

module xml_entity_decoding_tokenizer #(
    parameter int ENTITY_MAX = xedt_pkg::ENTITY_MAX_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire xedt_pkg::t_in  i_in_word,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output xedt_pkg::t_out      o_out_word
);
    import xedt_pkg::*;

    t_cmd    cmd;
    t_status status;

    xedt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    xedt_dp #(
        .ENTITY_MAX (ENTITY_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_word  (o_out_word),
        .o_out_valid (o_out_valid)
    );

endmodule

`default_nettype wire
